>>> rtl/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, widths and codes for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int RES_W     = (DATA_W < 32) ? DATA_W : 32;

    // b may be conjugated, so operands carry one extra bit
    localparam int OPD_W  = DATA_W + 1;
    localparam int SUM_W  = 2 * OPD_W;
    localparam int HI_W   = SUM_W - FRAC_BITS;
    localparam int SQ_W   = 2 * DATA_W + 1;
    localparam int DEN_W  = SQ_W - FRAC_BITS;
    localparam int ROOT_W = DATA_W + 1;
    localparam int DIVD_W = HI_W + FRAC_BITS;
    localparam int QUO_W  = RES_W;

    typedef enum logic [2:0] {
        CMD_MUL   = 3'd0,
        CMD_DIV   = 3'd1,
        CMD_NORM  = 3'd2,
        CMD_CONJ  = 3'd3,
        CMD_INV   = 3'd4,
        CMD_MAG   = 3'd5,
        CMD_MAGSQ = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] a_w;
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
        logic signed [DATA_W-1:0] b_w;
        logic signed [DATA_W-1:0] b_x;
        logic signed [DATA_W-1:0] b_y;
        logic signed [DATA_W-1:0] b_z;
    } qau_in_t;

    typedef struct packed {
        logic signed [RES_W-1:0] r_w;
        logic signed [RES_W-1:0] r_x;
        logic signed [RES_W-1:0] r_y;
        logic signed [RES_W-1:0] r_z;
        logic [1:0]              status;
    } qau_out_t;

    // front end to root chain: products already summed and floored
    typedef struct packed {
        logic [2:0]                 cmd;
        logic [3:0][DATA_W-1:0]     a;
        logic [3:0][HI_W-1:0]       h;
        logic [SQ_W-1:0]            sq;
    } qau_mid_t;

endpackage

>>> rtl/qau_front.sv
// ----------------------------------------------------------------------------
// qau_front
// Input register, product array and sum stage: Hamilton sums and |x|^2.
// ----------------------------------------------------------------------------
module qau_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  qau_pkg::qau_in_t  req,
    output logic              mid_valid,
    output qau_pkg::qau_mid_t mid
);

    localparam int DW = qau_pkg::DATA_W;
    localparam int OW = qau_pkg::OPD_W;
    localparam int PW = qau_pkg::SUM_W;
    localparam int SW = qau_pkg::SQ_W;

    qau_pkg::qau_in_t  req_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic [2:0]        cmd2_reg;
    logic [3:0][DW-1:0] a2_reg;
    logic signed [PW-1:0] prod_reg [4][4];
    logic [2*DW-1:0]   sqp_reg [4];
    qau_pkg::qau_mid_t mid_reg;

    logic [3:0][DW-1:0]   av;
    logic [3:0][DW-1:0]   bv;
    logic                 is_div;
    logic signed [OW-1:0] aa [4];
    logic signed [OW-1:0] bb [4];
    logic signed [DW-1:0] sv [4];
    logic signed [PW-1:0] prod_next [4][4];
    logic signed [2*DW-1:0] sqs [4];
    logic signed [PW-1:0] s [4];
    qau_pkg::qau_mid_t    mid_next;

    always_comb
    begin
        av = {req_reg.a_z, req_reg.a_y, req_reg.a_x, req_reg.a_w};
        bv = {req_reg.b_z, req_reg.b_y, req_reg.b_x, req_reg.b_w};
        is_div = (req_reg.cmd == qau_pkg::CMD_DIV);
        for (int i = 0; i < 4; i++)
        begin
            aa[i] = OW'($signed(av[i]));
            bb[i] = OW'($signed(bv[i]));
            // a/b works from a*conj(b)
            if (is_div && i != 0)
            begin
                bb[i] = -OW'($signed(bv[i]));
            end
            sv[i]  = is_div ? $signed(bv[i]) : $signed(av[i]);
            sqs[i] = sv[i] * sv[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_next[i][j] = aa[i] * bb[j];
            end
        end
    end

    always_comb
    begin
        s[0] = prod_reg[0][0] - prod_reg[1][1] - prod_reg[2][2] - prod_reg[3][3];
        s[1] = prod_reg[0][1] + prod_reg[1][0] + prod_reg[2][3] - prod_reg[3][2];
        s[2] = prod_reg[0][2] - prod_reg[1][3] + prod_reg[2][0] + prod_reg[3][1];
        s[3] = prod_reg[0][3] + prod_reg[1][2] - prod_reg[2][1] + prod_reg[3][0];
        mid_next.cmd = cmd2_reg;
        mid_next.a   = a2_reg;
        for (int i = 0; i < 4; i++)
        begin
            mid_next.h[i] = s[i][PW-1:qau_pkg::FRAC_BITS];
        end
        mid_next.sq = SW'(sqp_reg[0]) + SW'(sqp_reg[1]) + SW'(sqp_reg[2]) + SW'(sqp_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req;
        cmd2_reg <= req_reg.cmd;
        a2_reg   <= av;
        for (int i = 0; i < 4; i++)
        begin
            sqp_reg[i] <= sqs[i];
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[i][j] <= prod_next[i][j];
            end
        end
        mid_reg <= mid_next;
    end

    assign mid_valid = v3_reg;
    assign mid       = mid_reg;

endmodule

>>> rtl/qau_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qau_sqrt_cell
// One bit of a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module qau_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                         clk,
    input  logic [qau_pkg::SQ_W-1:0]     rem_in,
    input  logic [qau_pkg::ROOT_W-1:0]   root_in,
    output logic [qau_pkg::SQ_W-1:0]     rem_out,
    output logic [qau_pkg::ROOT_W-1:0]   root_out
);

    localparam int SW = qau_pkg::SQ_W;
    localparam int RW = qau_pkg::ROOT_W;
    localparam int TW = SW + 2;

    logic [SW-1:0] rem_reg;
    logic [SW-1:0] rem_next;
    logic [RW-1:0] root_reg;
    logic [RW-1:0] root_next;
    logic [TW-1:0] trial;

    // (root + 2^k)^2 - root^2; the two terms never overlap
    always_comb
    begin
        trial = (TW'(root_in) << (STEP + 1)) | (TW'(1) << (2 * STEP));
        if (trial <= TW'(rem_in))
        begin
            rem_next  = rem_in - trial[SW-1:0];
            root_next = root_in | (RW'(1) << STEP);
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

>>> rtl/qau_div_cell.sv
// ----------------------------------------------------------------------------
// qau_div_cell
// One quotient bit of a restoring unsigned divider.
// ----------------------------------------------------------------------------
module qau_div_cell #(
    parameter int STEP = 0
) (
    input  logic                         clk,
    input  logic [qau_pkg::DIVD_W-1:0]   rem_in,
    input  logic [qau_pkg::DEN_W-1:0]    den,
    input  logic [qau_pkg::QUO_W-1:0]    q_in,
    output logic [qau_pkg::DIVD_W-1:0]   rem_out,
    output logic [qau_pkg::QUO_W-1:0]    q_out
);

    localparam int DW = qau_pkg::DIVD_W;
    localparam int QW = qau_pkg::QUO_W;

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] q_reg;
    logic [QW-1:0] q_next;
    logic          ge;

    // rem >= den<<k is the same test as rem>>k >= den
    always_comb
    begin
        ge = (rem_in >> STEP) >= DW'(den);
        if (ge)
        begin
            rem_next = rem_in - (DW'(den) << STEP);
            q_next   = q_in | (QW'(1) << STEP);
        end
        else
        begin
            rem_next = rem_in;
            q_next   = q_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

>>> rtl/quaternion_arith_unit.sv
// ----------------------------------------------------------------------------
// quaternion_arith_unit
// Pipelined Q16.16 quaternion unit: product, quotient, normalize, conjugate,
// inverse, magnitude and squared magnitude.
// ----------------------------------------------------------------------------
// A word is taken on every clock in which start is high; busy never rises.
// Each word gives one result, strobed by done for a single cycle, in order.
// The result passes the front end, the 33-cell root chain, then the 32-cell
// quotient chain and the output register; every opcode passes both chains so
// results never reorder. There is no backpressure on the result side.
module quaternion_arith_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  qau_pkg::qau_in_t  req,
    output logic              done,
    output qau_pkg::qau_out_t rsp
);

    localparam int RES_W   = qau_pkg::RES_W;
    localparam int HI_W    = qau_pkg::HI_W;
    localparam int SQ_W    = qau_pkg::SQ_W;
    localparam int DEN_W   = qau_pkg::DEN_W;
    localparam int ROOT_W  = qau_pkg::ROOT_W;
    localparam int DIVD_W  = qau_pkg::DIVD_W;
    localparam int QUO_W   = qau_pkg::QUO_W;
    localparam int DATA_W  = qau_pkg::DATA_W;
    localparam int FB      = qau_pkg::FRAC_BITS;
    localparam int CLAMP_W = HI_W + 1;
    localparam int CMP_W   = DEN_W + QUO_W;
    localparam int LATENCY = 3 + ROOT_W + 1 + QUO_W + 1;

    localparam logic signed [CLAMP_W-1:0] C_MAX =
        {{(CLAMP_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
    localparam logic signed [CLAMP_W-1:0] C_MIN =
        {{(CLAMP_W-RES_W+1){1'b1}}, {(RES_W-1){1'b0}}};

    typedef struct packed {
        logic                   is_div;
        logic                   zero;
        logic [3:0]             neg;
        logic [3:0]             mzero;
        logic [3:0]             povf;
        logic [3:0][RES_W-1:0]  byp;
        logic                   byp_flag;
        logic [DEN_W-1:0]       den;
    } tail_t;

    function automatic logic out_of_range(input logic signed [CLAMP_W-1:0] v);
        return (v > C_MAX) || (v < C_MIN);
    endfunction

    function automatic logic [RES_W-1:0] clamp(input logic signed [CLAMP_W-1:0] v);
        logic [RES_W-1:0] res;
        if (v > C_MAX)
        begin
            res = C_MAX[RES_W-1:0];
        end
        else if (v < C_MIN)
        begin
            res = C_MIN[RES_W-1:0];
        end
        else
        begin
            res = v[RES_W-1:0];
        end
        return res;
    endfunction

    // front end
    logic              mid_valid;
    qau_pkg::qau_mid_t mid_f;

    qau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .mid_valid (mid_valid),
        .mid       (mid_f)
    );

    // root chain
    logic [SQ_W-1:0]   rem_w  [ROOT_W+1];
    logic [ROOT_W-1:0] root_w [ROOT_W+1];
    qau_pkg::qau_mid_t mid_reg [ROOT_W];
    logic [ROOT_W-1:0] mv_reg;

    assign rem_w[0]  = mid_f.sq;
    assign root_w[0] = '0;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        qau_sqrt_cell #(.STEP(ROOT_W - 1 - i)) u_cell (
            .clk      (clk),
            .rem_in   (rem_w[i]),
            .root_in  (root_w[i]),
            .rem_out  (rem_w[i+1]),
            .root_out (root_w[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        mid_reg[0] <= mid_f;
        for (int i = 1; i < ROOT_W; i++)
        begin
            mid_reg[i] <= mid_reg[i-1];
        end
    end

    // operand set-up for the quotient chain
    qau_pkg::qau_mid_t            ms;
    logic [ROOT_W-1:0]            root;
    tail_t                        tail_next;
    logic [3:0][DIVD_W-1:0]       dvd_next;
    logic signed [HI_W-1:0]       num;
    logic [HI_W-1:0]              mag;
    logic signed [CLAMP_W-1:0]    bv;

    always_comb
    begin
        ms   = mid_reg[ROOT_W-1];
        root = root_w[ROOT_W];
        tail_next.is_div = (ms.cmd == qau_pkg::CMD_DIV) || (ms.cmd == qau_pkg::CMD_NORM)
                        || (ms.cmd == qau_pkg::CMD_INV);
        tail_next.zero   = tail_next.is_div && (ms.sq == '0);
        tail_next.den    = (ms.cmd == qau_pkg::CMD_NORM) ? DEN_W'(root) : ms.sq[SQ_W-1:FB];
        tail_next.byp_flag = 1'b0;
        for (int l = 0; l < 4; l++)
        begin
            case (ms.cmd)
                qau_pkg::CMD_DIV:
                begin
                    num = $signed(ms.h[l]);
                end
                qau_pkg::CMD_INV:
                begin
                    num = (l == 0) ? HI_W'($signed(ms.a[l])) : -HI_W'($signed(ms.a[l]));
                end
                default:
                begin
                    num = HI_W'($signed(ms.a[l]));
                end
            endcase
            tail_next.neg[l]   = num[HI_W-1];
            mag                = num[HI_W-1] ? HI_W'(-num) : HI_W'(num);
            tail_next.mzero[l] = (mag == '0);
            dvd_next[l]        = {mag, {FB{1'b0}}};
            tail_next.povf[l]  = CMP_W'(dvd_next[l]) >= (CMP_W'(tail_next.den) << QUO_W);

            case (ms.cmd)
                qau_pkg::CMD_MUL:
                begin
                    bv = CLAMP_W'($signed(ms.h[l]));
                end
                qau_pkg::CMD_CONJ:
                begin
                    bv = (l == 0) ? CLAMP_W'($signed(ms.a[l])) : -CLAMP_W'($signed(ms.a[l]));
                end
                qau_pkg::CMD_MAG:
                begin
                    bv = (l == 0) ? CLAMP_W'(root) : '0;
                end
                qau_pkg::CMD_MAGSQ:
                begin
                    bv = (l == 0) ? CLAMP_W'(ms.sq[SQ_W-1:FB]) : '0;
                end
                default:
                begin
                    bv = '0;
                end
            endcase
            tail_next.byp[l] = clamp(bv);
            if (out_of_range(bv))
            begin
                tail_next.byp_flag = 1'b1;
            end
        end
    end

    // quotient chain, four lanes
    tail_t                tail_reg [QUO_W+1];
    logic [QUO_W:0]       tv_reg;
    logic [DIVD_W-1:0]    dvd_reg [4];
    logic [DIVD_W-1:0]    drem_w [4][QUO_W+1];
    logic [QUO_W-1:0]     q_w [4][QUO_W+1];

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        assign drem_w[l][0] = dvd_reg[l];
        assign q_w[l][0]    = '0;
        for (genvar j = 0; j < QUO_W; j++)
        begin : g_step
            qau_div_cell #(.STEP(QUO_W - 1 - j)) u_cell (
                .clk     (clk),
                .rem_in  (drem_w[l][j]),
                .den     (tail_reg[j].den),
                .q_in    (q_w[l][j]),
                .rem_out (drem_w[l][j+1]),
                .q_out   (q_w[l][j+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg[0] <= tail_next;
        for (int j = 1; j <= QUO_W; j++)
        begin
            tail_reg[j] <= tail_reg[j-1];
        end
        for (int l = 0; l < 4; l++)
        begin
            dvd_reg[l] <= dvd_next[l];
        end
    end

    // result assembly
    tail_t                 ts;
    logic [3:0][RES_W-1:0] r;
    logic                  dflag;
    logic [RES_W-1:0]      lim;
    logic [RES_W-1:0]      val;
    qau_pkg::qau_out_t     rsp_next;
    qau_pkg::qau_out_t     rsp_reg;
    logic                  done_reg;

    always_comb
    begin
        ts    = tail_reg[QUO_W];
        dflag = 1'b0;
        for (int l = 0; l < 4; l++)
        begin
            lim = ts.neg[l] ? C_MIN[RES_W-1:0] : C_MAX[RES_W-1:0];
            val = q_w[l][QUO_W];
            if (ts.zero)
            begin
                r[l] = '0;
            end
            else if (!ts.is_div)
            begin
                r[l] = ts.byp[l];
            end
            else if (ts.mzero[l])
            begin
                r[l] = '0;
            end
            else if (ts.povf[l])
            begin
                r[l]  = lim;
                dflag = 1'b1;
            end
            else
            begin
                if (val > lim)
                begin
                    val   = lim;
                    dflag = 1'b1;
                end
                r[l] = ts.neg[l] ? -val : val;
            end
        end
        rsp_next.r_w = r[0];
        rsp_next.r_x = r[1];
        rsp_next.r_y = r[2];
        rsp_next.r_z = r[3];
        if (ts.zero)
        begin
            rsp_next.status = qau_pkg::ST_ZERO;
        end
        else if (dflag || ts.byp_flag)
        begin
            rsp_next.status = qau_pkg::ST_SAT;
        end
        else
        begin
            rsp_next.status = qau_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg   <= '0;
            tv_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            mv_reg   <= {mv_reg[ROOT_W-2:0], mid_valid};
            tv_reg   <= {tv_reg[QUO_W-1:0], mv_reg[ROOT_W-1]};
            done_reg <= tv_reg[QUO_W];
        end
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result strobe missing after accepted word");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a matching word");

    a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == qau_pkg::ST_ZERO) |->
        (rsp.r_w == '0 && rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0))
        else $error("zero-divisor result carries nonzero data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == qau_pkg::ST_OK || rsp.status == qau_pkg::ST_ZERO
                  || rsp.status == qau_pkg::ST_SAT))
        else $error("undefined status code");
`endif

endmodule
